### hdl/iwo_pkg.sv
// Shared constants, reset values, register indexes and helper functions
// for the IMU/wheel odometry block. No dependencies.
`default_nettype none

package iwo_pkg;

  // CORDIC rotation count (12..32)
  localparam int CORDIC_STEPS = 24;
  localparam int CNT_W = 6;
  localparam int Z_W = 36;
  localparam int XY_W = 34;

  localparam logic signed [32:0] PI_Q28     = 33'sd843314857;
  localparam logic signed [32:0] TWO_PI_Q28 = 33'sd1686629713;

  localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;

  localparam logic [23:0]        DPR_RST     = 24'd3162431;
  localparam logic signed [31:0] START_X_RST = 32'sd0;
  localparam logic signed [31:0] START_Y_RST = 32'sd0;
  localparam logic signed [31:0] START_H_RST = -32'sd26353589;

  localparam logic [1:0] REG_DPR     = 2'd0;
  localparam logic [1:0] REG_START_X = 2'd1;
  localparam logic [1:0] REG_START_Y = 2'd2;
  localparam logic [1:0] REG_START_H = 2'd3;

  // arctan(2^-i) in Q1.30, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // clip to signed 32-bit range, flag in the top bit
  function automatic logic [32:0] clip32(input logic signed [39:0] v);
    logic [32:0] r;
    if (v > 40'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
    else if (v < -40'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // clip a body-frame step to +-(2^31-1), flag in the top bit
  function automatic logic [32:0] clip_step(input logic signed [51:0] v);
    logic [32:0] r;
    if (v > 52'sd2147483647) r = {1'b1, 32'h7FFFFFFF};
    else if (v < -52'sd2147483647) r = {1'b1, 32'h80000001};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/imu_wheel_odometry.sv
// Top level of the IMU/wheel odometry block: APB registers, sequencer,
// shared multiplier and pose accumulators. Depends on iwo_pkg, iwo_cordic.
`default_nettype none

// Dead-reckoning odometry. Each input item is one control tick carrying the
// absolute IMU heading (Q3.28) and both tracking-wheel positions (Q16.16).
// The block takes one item at a time: in_ready is high only while the
// sequencer is idle, and an item goes from acceptance to a registered
// result through one heading-update step, one CORDIC start step, the
// CORDIC itself (five modulo steps, a wrap step, a fold step, one rotation
// step per cycle and a sign-fix step), a wait step to see it finish, the
// rotation of the wheel step into the world frame on the one shared 33x33
// multiplier and one write step; the wheel scaling multiplies overlap the
// CORDIC run.
// The write cycle holds while the previous result still waits. The result
// sits in an output register, so the next item is taken while it waits for
// out_ready.
// The first item only primes the stored samples (zero step). With restart
// set the pose is loaded from the start registers after the update and
// saturated reads 0. Registers: 0x0 distance_per_rev, 0x4 start_x,
// 0x8 start_y, 0xC start_heading; write them only while the block is idle.
module imu_wheel_odometry (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [30:0] in_imu_heading,
  input  wire logic signed [31:0] in_x_wheel_revs,
  input  wire logic signed [31:0] in_y_wheel_revs,
  input  wire logic               in_restart,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pose_x,
  output logic signed [31:0]      out_pose_y,
  output logic signed [31:0]      out_pose_heading,
  output logic                    out_saturated,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HEAD  = 5'd1;
  localparam logic [4:0] S_W0    = 5'd2;
  localparam logic [4:0] S_W1    = 5'd3;
  localparam logic [4:0] S_W2    = 5'd4;
  localparam logic [4:0] S_W3    = 5'd5;
  localparam logic [4:0] S_W4    = 5'd6;
  localparam logic [4:0] S_W5    = 5'd7;
  localparam logic [4:0] S_W6    = 5'd8;
  localparam logic [4:0] S_CWAIT = 5'd9;
  localparam logic [4:0] S_R0    = 5'd10;
  localparam logic [4:0] S_R1    = 5'd11;
  localparam logic [4:0] S_R2    = 5'd12;
  localparam logic [4:0] S_R3    = 5'd13;
  localparam logic [4:0] S_R4    = 5'd14;
  localparam logic [4:0] S_R5    = 5'd15;
  localparam logic [4:0] S_UPD   = 5'd16;

  logic [4:0] state_r;

  // configuration registers
  logic [23:0]        dpr_r;
  logic signed [31:0] start_x_r, start_y_r, start_h_r;

  // kept samples and pose
  logic signed [30:0] last_h_r;
  logic signed [31:0] last_x_r, last_y_r;
  logic               primed_r;
  logic signed [31:0] pose_x_r, pose_y_r, pose_h_r;

  // per-item working registers
  logic signed [32:0] dh_r, dxr_r, dyr_r;
  logic               restart_r;
  logic               sat_r;
  logic signed [65:0] prod_r;
  logic signed [67:0] acc_r;
  logic signed [31:0] dx_r, dy_r;
  logic signed [37:0] wx_r, wy_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_h_r;
  logic               out_sat_r;

  logic in_fire, cfg_wr, slot_free;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign slot_free = !out_valid_r || out_ready;
  assign pready    = 1'b1;

  always_comb begin
    case (paddr[3:2])
      iwo_pkg::REG_DPR:     prdata = {8'h00, dpr_r};
      iwo_pkg::REG_START_X: prdata = start_x_r;
      iwo_pkg::REG_START_Y: prdata = start_y_r;
      iwo_pkg::REG_START_H: prdata = start_h_r;
      default:              prdata = '0;
    endcase
  end

  // First tick: diff against the new sample itself, giving a zero step.
  logic signed [30:0] lh;
  logic signed [31:0] lx, ly;
  assign lh = primed_r ? last_h_r : in_imu_heading;
  assign lx = primed_r ? last_x_r : in_x_wheel_revs;
  assign ly = primed_r ? last_y_r : in_y_wheel_revs;

  // Heading step: wrap once, round Q3.28 to Q8.24, accumulate with clip.
  logic signed [32:0] dh_w, dh_q;
  logic [32:0]        h_clip;
  always_comb begin
    if (dh_r > iwo_pkg::PI_Q28) dh_w = dh_r - iwo_pkg::TWO_PI_Q28;
    else if (dh_r < -iwo_pkg::PI_Q28) dh_w = dh_r + iwo_pkg::TWO_PI_Q28;
    else dh_w = dh_r;
    dh_q   = (dh_w + 33'sd8) >>> 4;
    h_clip = iwo_pkg::clip32(40'(pose_h_r) + 40'(dh_q));
  end

  // CORDIC on the updated heading, started as the wheel multiplies begin
  logic                             cordic_done;
  logic signed [iwo_pkg::XY_W-1:0]  cos_q30, sin_q30;

  iwo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_W0),
    .angle   (pose_h_r),
    .done    (cordic_done),
    .cos_out (cos_q30),
    .sin_out (sin_q30)
  );

  // Shared multiplier operands; product registered every cycle.
  logic signed [32:0] mul_a, mul_b;
  logic signed [32:0] dpr_lo, dpr_hi, c33, s33;
  assign dpr_lo = $signed({21'b0, dpr_r[11:0]});
  assign dpr_hi = $signed({21'b0, dpr_r[23:12]});
  assign c33    = cos_q30[32:0];
  assign s33    = sin_q30[32:0];

  always_comb begin
    case (state_r)
      S_W0:    begin mul_a = dxr_r;      mul_b = dpr_lo; end
      S_W1:    begin mul_a = dxr_r;      mul_b = dpr_hi; end
      S_W3:    begin mul_a = dyr_r;      mul_b = dpr_lo; end
      S_W4:    begin mul_a = dyr_r;      mul_b = dpr_hi; end
      S_R0:    begin mul_a = 33'(dx_r);  mul_b = c33;    end
      S_R1:    begin mul_a = 33'(dy_r);  mul_b = s33;    end
      S_R2:    begin mul_a = 33'(dx_r);  mul_b = s33;    end
      S_R3:    begin mul_a = 33'(dy_r);  mul_b = c33;    end
      default: begin mul_a = '0;         mul_b = '0;     end
    endcase
  end

  // Rounding of the accumulator: Q16.16*Q0.24 to Q8.24, Q8.24*Q1.30 to Q8.24
  logic signed [67:0] prod_x, prod_sh, acc_r16, acc_r30;
  logic [32:0]        dx_clip, dy_clip;
  assign prod_x  = 68'(prod_r);
  assign prod_sh = prod_x <<< 12;
  assign acc_r16 = (acc_r + (68'sd1 <<< 15)) >>> 16;
  assign acc_r30 = (acc_r + (68'sd1 <<< 29)) >>> 30;
  assign dx_clip = iwo_pkg::clip_step(acc_r16[51:0]);
  assign dy_clip = iwo_pkg::clip_step(-acc_r16[51:0]);

  // World-frame update of x and y
  logic [32:0] x_clip, y_clip;
  assign x_clip = iwo_pkg::clip32(40'(pose_x_r) + 40'(wx_r));
  assign y_clip = iwo_pkg::clip32(40'(pose_y_r) + 40'(wy_r));

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dpr_r       <= iwo_pkg::DPR_RST;
      start_x_r   <= iwo_pkg::START_X_RST;
      start_y_r   <= iwo_pkg::START_Y_RST;
      start_h_r   <= iwo_pkg::START_H_RST;
      last_h_r    <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      primed_r    <= 1'b0;
      pose_x_r    <= iwo_pkg::START_X_RST;
      pose_y_r    <= iwo_pkg::START_Y_RST;
      pose_h_r    <= iwo_pkg::START_H_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          iwo_pkg::REG_DPR:     dpr_r     <= pwdata[23:0];
          iwo_pkg::REG_START_X: start_x_r <= pwdata;
          iwo_pkg::REG_START_Y: start_y_r <= pwdata;
          iwo_pkg::REG_START_H: start_h_r <= pwdata;
          default: ;
        endcase
      end

      // drop valid once taken, unless a new result is written this cycle
      if (out_valid_r && out_ready && (state_r != S_UPD)) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            dh_r      <= 33'(lh) - 33'(in_imu_heading);
            dxr_r     <= 33'(in_x_wheel_revs) - 33'(lx);
            dyr_r     <= 33'(in_y_wheel_revs) - 33'(ly);
            last_h_r  <= in_imu_heading;
            last_x_r  <= in_x_wheel_revs;
            last_y_r  <= in_y_wheel_revs;
            primed_r  <= 1'b1;
            restart_r <= in_restart;
            sat_r     <= 1'b0;
            state_r   <= S_HEAD;
          end
        end
        S_HEAD: begin
          pose_h_r <= h_clip[31:0];
          sat_r    <= sat_r | h_clip[32];
          state_r  <= S_W0;
        end
        S_W0: state_r <= S_W1;
        S_W1: begin
          acc_r   <= prod_x;
          state_r <= S_W2;
        end
        S_W2: begin
          acc_r   <= acc_r + prod_sh;
          state_r <= S_W3;
        end
        S_W3: begin
          dx_r    <= dx_clip[31:0];
          sat_r   <= sat_r | dx_clip[32];
          state_r <= S_W4;
        end
        S_W4: begin
          acc_r   <= prod_x;
          state_r <= S_W5;
        end
        S_W5: begin
          acc_r   <= acc_r + prod_sh;
          state_r <= S_W6;
        end
        S_W6: begin
          // y step is negated before the clip
          dy_r    <= dy_clip[31:0];
          sat_r   <= sat_r | dy_clip[32];
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cordic_done) state_r <= S_R0;
        end
        S_R0: state_r <= S_R1;
        S_R1: begin
          acc_r   <= prod_x;
          state_r <= S_R2;
        end
        S_R2: begin
          acc_r   <= acc_r - prod_x;
          state_r <= S_R3;
        end
        S_R3: begin
          wx_r    <= acc_r30[37:0];
          acc_r   <= prod_x;
          state_r <= S_R4;
        end
        S_R4: begin
          acc_r   <= acc_r + prod_x;
          state_r <= S_R5;
        end
        S_R5: begin
          wy_r    <= acc_r30[37:0];
          state_r <= S_UPD;
        end
        S_UPD: begin
          // hold until the output register is free
          if (slot_free) begin
            if (restart_r) begin
              pose_x_r  <= start_x_r;
              pose_y_r  <= start_y_r;
              pose_h_r  <= start_h_r;
              out_x_r   <= start_x_r;
              out_y_r   <= start_y_r;
              out_h_r   <= start_h_r;
              out_sat_r <= 1'b0;
            end else begin
              pose_x_r  <= x_clip[31:0];
              pose_y_r  <= y_clip[31:0];
              out_x_r   <= x_clip[31:0];
              out_y_r   <= y_clip[31:0];
              out_h_r   <= pose_h_r;
              out_sat_r <= sat_r | x_clip[32] | y_clip[32];
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = out_x_r;
  assign out_pose_y       = out_y_r;
  assign out_pose_heading = out_h_r;
  assign out_saturated    = out_sat_r;

  // busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken again right after an accepted item");

  // every accepted item leaves the block primed
  a_primed: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> primed_r)
    else $error("primed not set after an accepted item");

  // rotation starts only on a finished sine/cosine
  a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_R0) |-> cordic_done)
    else $error("rotation started before CORDIC finished");

  // a restart item reports no clipping
  a_restart_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && slot_free && restart_r) |=> (out_valid && !out_saturated))
    else $error("restart result not loaded cleanly");

endmodule

`default_nettype wire

### hdl/iwo_cordic.sv
// Iterative sine/cosine unit: modulo-2pi reduction, quadrant fold and a
// rotation-mode CORDIC, one step per cycle. Depends on iwo_pkg.
`default_nettype none

module iwo_cordic (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [31:0]              angle,
  output logic                                 done,
  output logic signed [iwo_pkg::XY_W-1:0]      cos_out,
  output logic signed [iwo_pkg::XY_W-1:0]      sin_out
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MOD  = 3'd1;
  localparam logic [2:0] C_WRAP = 3'd2;
  localparam logic [2:0] C_FOLD = 3'd3;
  localparam logic [2:0] C_ITER = 3'd4;
  localparam logic [2:0] C_FLIP = 3'd5;

  logic [2:0]                         st_r;
  logic [37:0]                        rem_r;
  logic                               neg_r;
  logic [2:0]                         k_r;
  logic signed [iwo_pkg::Z_W-1:0]     z_r;
  logic                               flip_r;
  logic signed [iwo_pkg::XY_W-1:0]    x_r, y_r;
  logic [iwo_pkg::CNT_W-1:0]          cnt_r;
  logic                               done_r;
  logic signed [iwo_pkg::XY_W-1:0]    cos_r, sin_r;

  logic signed [37:0]                 ang64;
  logic [37:0]                        m_sh;
  logic signed [iwo_pkg::Z_W-1:0]     rs;
  logic signed [iwo_pkg::XY_W-1:0]    xs, ys;
  logic signed [iwo_pkg::Z_W-1:0]     at;

  assign ang64 = $signed({angle, 6'b0});
  assign m_sh  = {2'b00, iwo_pkg::TWO_PI_Q30} << k_r;
  assign rs    = neg_r ? -$signed({3'b000, rem_r[32:0]}) : $signed({3'b000, rem_r[32:0]});
  assign xs    = y_r >>> cnt_r[4:0];
  assign ys    = x_r >>> cnt_r[4:0];
  assign at    = $signed({4'b0000, iwo_pkg::atan_q30(cnt_r[4:0])});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      case (st_r)
        C_IDLE: begin
          if (start) begin
            rem_r  <= angle[31] ? 38'(-ang64) : 38'(ang64);
            neg_r  <= angle[31];
            k_r    <= 3'd4;
            done_r <= 1'b0;
            st_r   <= C_MOD;
          end
        end
        C_MOD: begin
          if (rem_r >= m_sh) rem_r <= rem_r - m_sh;
          k_r <= k_r - 3'd1;
          if (k_r == 3'd0) st_r <= C_WRAP;
        end
        C_WRAP: begin
          if (rs > iwo_pkg::PI_Q30) z_r <= rs - iwo_pkg::TWO_PI_Q30;
          else if (rs < -iwo_pkg::PI_Q30) z_r <= rs + iwo_pkg::TWO_PI_Q30;
          else z_r <= rs;
          st_r <= C_FOLD;
        end
        C_FOLD: begin
          if (z_r > iwo_pkg::HALF_PI_Q30) begin
            z_r    <= z_r - iwo_pkg::PI_Q30;
            flip_r <= 1'b1;
          end else if (z_r < -iwo_pkg::HALF_PI_Q30) begin
            z_r    <= z_r + iwo_pkg::PI_Q30;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
          x_r   <= iwo_pkg::GAIN_Q30;
          y_r   <= '0;
          cnt_r <= '0;
          st_r  <= C_ITER;
        end
        C_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - xs;
            y_r <= y_r + ys;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + xs;
            y_r <= y_r - ys;
            z_r <= z_r + at;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == iwo_pkg::CNT_W'(iwo_pkg::CORDIC_STEPS - 1)) st_r <= C_FLIP;
        end
        C_FLIP: begin
          cos_r  <= flip_r ? -x_r : x_r;
          sin_r  <= flip_r ? -y_r : y_r;
          done_r <= 1'b1;
          st_r   <= C_IDLE;
        end
        default: st_r <= C_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign cos_out = cos_r;
  assign sin_out = sin_r;

endmodule

`default_nettype wire

### tb/odometry_checker.sv
// Checker for the IMU/wheel odometry block: tracks register writes, predicts
// each pose update and compares it with the result channel. Depends on iwo_pkg.
`timescale 1ns / 1ps

module odometry_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [30:0] in_imu_heading,
  input  logic signed [31:0] in_x_wheel_revs,
  input  logic signed [31:0] in_y_wheel_revs,
  input  logic               in_restart,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pose_x,
  input  logic signed [31:0] out_pose_y,
  input  logic signed [31:0] out_pose_heading,
  input  logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 failures,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] heading;
    logic               sat;
  } pose_t;

  localparam longint TURN_Q28 = 64'sd1686629713;
  localparam longint TURN_Q30 = 64'sd6746518852;
  localparam longint HALF_TURN_Q28 = 64'sd843314857;
  localparam longint HALF_TURN_Q30 = 64'sd3373259426;
  localparam longint QUARTER_Q30 = 64'sd1686629713;
  localparam longint STEP_MAX = 64'sd2147483647;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  // arctan(2^-i) in Q1.30, truncated
  localparam longint ARCTAN [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000};

  // register copies
  longint meters_per_rev, home_x, home_y, home_heading;
  // odometry state
  longint prev_heading, prev_x_revs, prev_y_revs;
  longint acc_x, acc_y, acc_heading;
  bit     primed;

  pose_t pose_queue[$];

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // cosine and sine in Q1.30 of a Q8.24 angle
  function automatic void rotate_unit(input longint ang24, output longint c,
                                      output longint s);
    longint r, x, y, dx, dy;
    bit     flip;
    int     n;
    r = (ang24 * 64) % TURN_Q30;
    x = longint'(iwo_pkg::GAIN_Q30);
    y = 0;
    flip = 1'b0;
    n = (iwo_pkg::CORDIC_STEPS > 32) ? 32 : iwo_pkg::CORDIC_STEPS;
    if (r > HALF_TURN_Q30) r -= TURN_Q30;
    else if (r < -HALF_TURN_Q30) r += TURN_Q30;
    if (r > QUARTER_Q30) begin
      r -= HALF_TURN_Q30;
      flip = 1'b1;
    end else if (r < -QUARTER_Q30) begin
      r += HALF_TURN_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx;
        y += dy;
        r -= ARCTAN[i];
      end else begin
        x += dx;
        y -= dy;
        r += ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // advance the dead-reckoned pose by one tick and return the reported pose
  function automatic pose_t advance_pose(input longint h, input longint xr,
                                         input longint yr, input bit restart);
    longint dh, dx, dy, c, s, wx, wy;
    bit     sat;
    pose_t  p;
    sat = 1'b0;
    if (!primed) begin
      prev_heading = h;
      prev_x_revs = xr;
      prev_y_revs = yr;
      primed = 1'b1;
    end
    dh = -(h - prev_heading);
    if (dh > HALF_TURN_Q28) dh -= TURN_Q28;
    else if (dh < -HALF_TURN_Q28) dh += TURN_Q28;
    acc_heading = clamp(acc_heading + ((dh + 8) >>> 4), I32_MIN, I32_MAX, sat);
    dx = ((xr - prev_x_revs) * meters_per_rev + 32768) >>> 16;
    dy = -(((yr - prev_y_revs) * meters_per_rev + 32768) >>> 16);
    dx = clamp(dx, -STEP_MAX, STEP_MAX, sat);
    dy = clamp(dy, -STEP_MAX, STEP_MAX, sat);
    rotate_unit(acc_heading, c, s);
    wx = (dx * c - dy * s + (64'sd1 <<< 29)) >>> 30;
    wy = (dx * s + dy * c + (64'sd1 <<< 29)) >>> 30;
    acc_x = clamp(acc_x + wx, I32_MIN, I32_MAX, sat);
    acc_y = clamp(acc_y + wy, I32_MIN, I32_MAX, sat);
    prev_heading = h;
    prev_x_revs = xr;
    prev_y_revs = yr;
    if (restart) begin
      acc_x = home_x;
      acc_y = home_y;
      acc_heading = home_heading;
      sat = 1'b0;
    end
    p.x = acc_x[31:0];
    p.y = acc_y[31:0];
    p.heading = acc_heading[31:0];
    p.sat = sat;
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t want;
    int    bad;
    if (!rst_n) begin
      meters_per_rev = longint'(iwo_pkg::DPR_RST);
      home_x = longint'(iwo_pkg::START_X_RST);
      home_y = longint'(iwo_pkg::START_Y_RST);
      home_heading = longint'(iwo_pkg::START_H_RST);
      prev_heading = 0;
      prev_x_revs = 0;
      prev_y_revs = 0;
      acc_x = home_x;
      acc_y = home_y;
      acc_heading = home_heading;
      primed = 1'b0;
      pose_queue.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          iwo_pkg::REG_DPR:     meters_per_rev = longint'(pwdata[23:0]);
          iwo_pkg::REG_START_X: home_x = longint'($signed(pwdata));
          iwo_pkg::REG_START_Y: home_y = longint'($signed(pwdata));
          iwo_pkg::REG_START_H: home_heading = longint'($signed(pwdata));
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pose_queue.push_back(advance_pose(longint'(in_imu_heading),
                                          longint'(in_x_wheel_revs),
                                          longint'(in_y_wheel_revs), in_restart));
      if (out_valid && out_ready) begin
        if (pose_queue.size() == 0) begin
          $error("result with no tick pending");
          bad++;
        end else begin
          want = pose_queue.pop_front();
          if (out_pose_x !== want.x) begin
            $error("pose_x: expected %0d, got %0d", want.x, out_pose_x);
            bad++;
          end
          if (out_pose_y !== want.y) begin
            $error("pose_y: expected %0d, got %0d", want.y, out_pose_y);
            bad++;
          end
          if (out_pose_heading !== want.heading) begin
            $error("pose_heading: expected %0d, got %0d", want.heading, out_pose_heading);
            bad++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0b, got %0b", want.sat, out_saturated);
            bad++;
          end
        end
      end
      failures <= failures + bad;
      pending <= pose_queue.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the odometry testbench: clock, reset, tick and register stimulus,
// verdict. Depends on iwo_pkg, imu_wheel_odometry and odometry_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_TICKS = 1750;
  localparam int SETTLE = 100;          // idle time added after the last pose has drained
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [30:0] HEAD_PI = 31'sd843314857;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [30:0] in_imu_heading;
  logic signed [31:0] in_x_wheel_revs;
  logic signed [31:0] in_y_wheel_revs;
  logic               in_restart;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pose_x;
  logic signed [31:0] out_pose_y;
  logic signed [31:0] out_pose_heading;
  logic               out_saturated;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int failures;
  int pending;
  int cycles = 0;
  int tx_idle_pct;      // chance in a hundred that the sender holds off
  int rx_idle_pct;      // chance in a hundred that the receiver stalls
  int ticks_sent;

  // running sensor values for well-formed motion
  logic signed [30:0] cur_heading;
  logic signed [31:0] cur_x_revs;
  logic signed [31:0] cur_y_revs;

  imu_wheel_odometry DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_imu_heading(in_imu_heading), .in_x_wheel_revs(in_x_wheel_revs),
    .in_y_wheel_revs(in_y_wheel_revs), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_pose_heading(out_pose_heading), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  odometry_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_imu_heading(in_imu_heading), .in_x_wheel_revs(in_x_wheel_revs),
    .in_y_wheel_revs(in_y_wheel_revs), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_pose_heading(out_pose_heading), .out_saturated(out_saturated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel at random; rx_idle_pct of zero keeps it open.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Signed random value in [-span, span].
  function automatic longint jitter(input int unsigned span);
    return longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  // Present one tick and hold it until the block takes it. A hold-off drops
  // valid for a random gap first; valid only falls when the gap is real.
  task automatic send_tick(input logic signed [30:0] h, input logic signed [31:0] xr,
                           input logic signed [31:0] yr, input logic rs);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_imu_heading <= h;
    in_x_wheel_revs <= xr;
    in_y_wheel_revs <= yr;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // Drop valid, let every pending pose drain, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase. The caller closes the bus.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [23:0] dpr, input logic [31:0] sx,
                           input logic [31:0] sy, input logic [31:0] sh);
    write_reg(iwo_pkg::REG_DPR, {8'h00, dpr});
    write_reg(iwo_pkg::REG_START_X, sx);
    write_reg(iwo_pkg::REG_START_Y, sy);
    write_reg(iwo_pkg::REG_START_H, sh);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly smooth motion with random content; sometimes raw noise, big
  // wheel jumps that can force clipping, or a restart.
  task automatic random_tick();
    int unsigned pick;
    longint      h;
    logic        rs;
    pick = $urandom_range(99);
    rs = ($urandom_range(99) < 3);
    if (pick < 10) begin
      cur_heading = 31'($urandom());
      cur_x_revs = $urandom();
      cur_y_revs = $urandom();
    end else if (pick < 16) begin
      cur_x_revs = cur_x_revs + 32'($urandom_range(1) ? 32'sh40000000 : -32'sh40000000);
      cur_y_revs = $urandom();
    end else begin
      h = longint'(cur_heading) + jitter(pick < 25 ? 32'h2000_0000 : 32'h0100_0000);
      // keep the heading inside +-pi like a real sensor
      if (h > longint'(HEAD_PI)) h -= 2 * longint'(HEAD_PI);
      if (h < -longint'(HEAD_PI)) h += 2 * longint'(HEAD_PI);
      cur_heading = h[30:0];
      cur_x_revs = cur_x_revs + 32'(jitter(pick < 30 ? 32'h0100_0000 : 32'h0004_0000));
      cur_y_revs = cur_y_revs + 32'(jitter(pick < 30 ? 32'h0100_0000 : 32'h0004_0000));
    end
    send_tick(cur_heading, cur_x_revs, cur_y_revs, rs);
  endtask

  initial begin
    ticks_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_imu_heading = '0;
    in_x_wheel_revs = '0;
    in_y_wheel_revs = '0;
    in_restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_heading = '0;
    cur_x_revs = '0;
    cur_y_revs = '0;
    tx_idle_pct = 7;
    rx_idle_pct = 56;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks on reset settings: first tick primes, then extremes.
    send_tick(31'sd1000, 32'sd65536, -32'sd65536, 1'b0);       // first tick, zero step
    send_tick(31'sd1000, 32'sd131072, -32'sd131072, 1'b0);     // one revolution each
    send_tick(HEAD_PI, 32'sd131072, -32'sd131072, 1'b0);       // heading jump to +pi
    send_tick(-HEAD_PI, 32'sd131072, -32'sd131072, 1'b0);      // wrap across +-pi
    send_tick(31'sh3FFFFFFF, 32'sd131072, 32'sd0, 1'b0);       // out-of-range heading
    send_tick(31'sh40000000, 32'sd0, 32'sd0, 1'b0);            // most negative pattern
    send_tick(31'sd0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);     // large wheel step, clip
    send_tick(31'sd0, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);     // large step back
    for (int i = 0; i < 6; i++)                                // run the pose into its limits
      send_tick(31'(i * 100000000), (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF,
                (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000, 1'b0);
    send_tick(31'sd0, 32'sd0, 32'sd0, 1'b1);                   // restart to home
    send_tick(31'sd0, 32'sd0, 32'sd0, 1'b0);
    drain();

    // Full scale distance, extreme home pose.
    write_all(24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_tick(31'sd0, 32'sd0, 32'sd0, 1'b1);
    send_tick(31'sd5000, 32'sd65536, 32'sd65536, 1'b0);
    send_tick(31'sd0, 32'sh7FFFFFFF, 32'sh80000000, 1'b0);
    for (int i = 0; i < RANDOM_TICKS / 3; i++) random_tick();
    drain();

    // Zero distance, opposite extremes, swap who stalls.
    tx_idle_pct = 56;
    rx_idle_pct = 7;
    write_all(24'h000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_tick(31'sd0, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
    for (int i = 0; i < RANDOM_TICKS / 3; i++) random_tick();
    drain();

    // Random settings, no stalls at all.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all(24'($urandom()), $urandom(), $urandom(), $urandom());
    send_tick(cur_heading, cur_x_revs, cur_y_revs, 1'b1);
    for (int i = 0; i < RANDOM_TICKS - 2 * (RANDOM_TICKS / 3); i++) random_tick();
    drain();

    $display("ran %0d odometry ticks over four register settings,", ticks_sent);
    $display("with sender and receiver stalls swapped and then removed");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
